### rtl/core/afrr_pkg.sv
// afrr_pkg: shared types, constants and register indexes for the affine residual RMS block.
// No dependencies.
package afrr_pkg;

  localparam int MaxSamplesDef = 65536;
  localparam logic signed [31:0] OneQ824 = 32'sh0100_0000;

  typedef enum logic [2:0] {
    REG_A = 3'd0,
    REG_B = 3'd1,
    REG_C = 3'd2,
    REG_D = 3'd3,
    REG_E = 3'd4,
    REG_F = 3'd5
  } reg_idx_t;

  // sample handed from the front part to the back part
  typedef struct packed {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic               last;
  } sample_t;

  typedef enum logic [2:0] {
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } back_state_t;

endpackage

### rtl/core/afrr_front.sv
// afrr_front: two-entry queue holding input samples for the back part.
// Depends on afrr_pkg.
module afrr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  afrr_pkg::sample_t in_item,
  output logic              q_valid,
  input  logic              q_take,
  output afrr_pkg::sample_t q_item
);

  afrr_pkg::sample_t mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              push;
  logic              pop;

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_item   = mem[rd_ptr];

  // hold payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/core/afrr_divsqrt.sv
// afrr_divsqrt: shared iterative unit for 64/17 division and 64-bit integer square root.
// Depends on nothing outside this file.
module afrr_divsqrt #(
  parameter int CountW = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              is_sqrt,
  input  logic [63:0]       num,
  input  logic [CountW-1:0] den,
  output logic              done,
  output logic [63:0]       result
);

  logic              busy;
  logic              mode;
  logic [6:0]        steps;
  logic [63:0]       acc;
  logic [65:0]       rem;
  logic [CountW-1:0] dv;
  logic [65:0]       trial;
  logic [65:0]       rem_sh;

  // one quotient bit or one root bit per cycle
  always_comb begin
    if (mode) begin
      rem_sh = {rem[63:0], acc[63:62]};
      trial  = {rem_sh} - {result[63:0], 2'b01};
    end else begin
      rem_sh = {rem[64:0], acc[63]};
      trial  = rem_sh - {{(66-CountW){1'b0}}, dv};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        mode   <= is_sqrt;
        acc    <= num;
        dv     <= den;
        rem    <= '0;
        result <= '0;
        steps  <= is_sqrt ? 7'd32 : 7'd64;
      end else if (busy) begin
        if (!trial[65]) begin
          rem    <= trial;
          result <= {result[62:0], 1'b1};
        end else begin
          rem    <= rem_sh;
          result <= {result[62:0], 1'b0};
        end
        acc   <= mode ? {acc[61:0], 2'b00} : {acc[62:0], 1'b0};
        steps <= steps - 7'd1;
        if (steps == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/afrr_back.sv
// afrr_back: affine products, residual accumulation and final RMS sequencing.
// Depends on afrr_pkg and afrr_divsqrt.
module afrr_back #(
  parameter int MaxSamples = afrr_pkg::MaxSamplesDef,
  parameter int CountW     = $clog2(MaxSamples + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_take,
  input  afrr_pkg::sample_t   q_item,
  input  logic signed [31:0]  coef_a,
  input  logic signed [31:0]  coef_b,
  input  logic signed [31:0]  coef_c,
  input  logic signed [31:0]  coef_d,
  input  logic signed [31:0]  coef_e,
  input  logic signed [31:0]  coef_f,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  predicted_x,
  output logic signed [31:0]  predicted_y,
  output logic [31:0]         rms_x,
  output logic [31:0]         rms_y,
  output logic [31:0]         rms_total,
  output logic                final_res
);

  afrr_pkg::back_state_t state, state_next;
  afrr_pkg::sample_t     cur;
  logic signed [63:0]    p1, p2;
  logic signed [31:0]    px;
  logic [63:0]           sum_x, sum_y, mean_x, mean_y;
  logic [CountW-1:0]     count;
  logic [CountW-1:0]     count_inc;
  logic [1:0]            phase;
  logic                  du_start, du_sqrt, du_done;
  logic [63:0]           du_num, du_res;
  logic [CountW-1:0]     du_den;
  logic [31:0]           rx, ry;

  logic signed [31:0]    mul_g1, mul_v1, mul_g2, mul_v2, mul_off;
  logic signed [31:0]    mul_off_reg;
  logic signed [65:0]    sum_p;
  logic signed [65:0]    rnd;
  logic signed [41:0]    pred_wide;
  logic signed [31:0]    pred_sat;
  logic signed [32:0]    res_pred_y;
  logic signed [32:0]    dx, dy;
  logic [31:0]           adx, ady;
  logic [64:0]           nsx, nsy;
  logic [64:0]           mt;
  logic                  out_free;

  assign out_free  = !out_valid || !out_stall;
  assign q_take    = (state == afrr_pkg::ST_MUL1) && q_valid && out_free;
  assign count_inc = (count < CountW'(MaxSamples)) ? count + 1'b1 : count;

  // select operands for the two multipliers
  always_comb begin
    if (state == afrr_pkg::ST_MUL1) begin
      mul_g1 = coef_b; mul_g2 = coef_c; mul_off = coef_a;
    end else begin
      mul_g1 = coef_e; mul_g2 = coef_f; mul_off = coef_d;
    end
    mul_v1 = (state == afrr_pkg::ST_MUL1) ? q_item.mx : cur.mx;
    mul_v2 = (state == afrr_pkg::ST_MUL1) ? q_item.my : cur.my;
  end

  // round, add offset and saturate registered products
  always_comb begin
    sum_p     = 66'(p1) + 66'(p2) + 66'sd8388608;
    rnd       = sum_p >>> 24;
    pred_wide = 42'(rnd) + 42'(mul_off_reg);
    if (pred_wide > 42'sd2147483647)       pred_sat = 32'sh7fffffff;
    else if (pred_wide < -42'sd2147483648) pred_sat = 32'sh80000000;
    else                                   pred_sat = pred_wide[31:0];
  end

  // residuals and saturating sums
  always_comb begin
    res_pred_y = 33'(pred_sat);
    dx  = 33'(cur.ex) - 33'(px);
    dy  = 33'(cur.ey) - res_pred_y;
    adx = dx[32] ? 32'(-dx) : dx[31:0];
    ady = dy[32] ? 32'(-dy) : dy[31:0];
    nsx = {1'b0, sum_x} + {1'b0, 64'(adx) * 64'(adx)};
    nsy = {1'b0, sum_y} + {1'b0, 64'(ady) * 64'(ady)};
    mt  = {1'b0, mean_x} + {1'b0, mean_y};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      afrr_pkg::ST_MUL1: if (q_take) state_next = afrr_pkg::ST_MUL2;
      afrr_pkg::ST_MUL2: state_next = afrr_pkg::ST_ACC;
      afrr_pkg::ST_ACC:  state_next = cur.last ? afrr_pkg::ST_DIV : afrr_pkg::ST_MUL1;
      afrr_pkg::ST_DIV:  if (du_done && phase == 2'd1) state_next = afrr_pkg::ST_SQRT;
      afrr_pkg::ST_SQRT: if (du_done && phase == 2'd2) state_next = afrr_pkg::ST_OUT;
      afrr_pkg::ST_OUT:  state_next = afrr_pkg::ST_MUL1;
      default:           state_next = afrr_pkg::ST_MUL1;
    endcase
  end

  // drive the shared divide and root unit
  always_comb begin
    du_start = 1'b0;
    du_sqrt  = 1'b0;
    du_num   = sum_x;
    du_den   = count;
    case (state)
      // divide the sum that includes the last sample
      afrr_pkg::ST_ACC: if (cur.last) begin
        du_start = 1'b1;
        du_num   = nsx[64] ? '1 : nsx[63:0];
        du_den   = count_inc;
      end
      afrr_pkg::ST_DIV: if (du_done && phase == 2'd0) begin
        du_start = 1'b1; du_num = sum_y;
      end else if (du_done && phase == 2'd1) begin
        du_start = 1'b1; du_sqrt = 1'b1; du_num = mean_x;
      end
      afrr_pkg::ST_SQRT: if (du_done && phase == 2'd0) begin
        du_start = 1'b1; du_sqrt = 1'b1; du_num = mean_y;
      end else if (du_done && phase == 2'd1) begin
        du_start = 1'b1; du_sqrt = 1'b1;
        du_num = mt[64] ? 64'hffff_ffff_ffff_ffff : mt[63:0];
      end
      default: du_start = 1'b0;
    endcase
  end

  afrr_divsqrt #(.CountW(CountW)) u_divsqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (du_start),
    .is_sqrt (du_sqrt),
    .num     (du_num),
    .den     (du_den),
    .done    (du_done),
    .result  (du_res)
  );

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= afrr_pkg::ST_MUL1;
      out_valid <= 1'b0;
      sum_x     <= '0;
      sum_y     <= '0;
      count     <= '0;
      phase     <= 2'd0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        afrr_pkg::ST_MUL1: if (q_take) cur <= q_item;
        afrr_pkg::ST_MUL2: px <= pred_sat;
        afrr_pkg::ST_ACC: begin
          sum_x <= nsx[64] ? '1 : nsx[63:0];
          sum_y <= nsy[64] ? '1 : nsy[63:0];
          count <= count_inc;
          phase <= 2'd0;
          if (!cur.last) begin
            out_valid   <= 1'b1;
            predicted_x <= px;
            predicted_y <= pred_sat;
            rms_x <= '0; rms_y <= '0; rms_total <= '0; final_res <= 1'b0;
          end else begin
            predicted_y <= pred_sat;
          end
        end
        afrr_pkg::ST_DIV: if (du_done) begin
          if (phase == 2'd0) mean_x <= du_res;
          else mean_y <= du_res;
          phase <= (phase == 2'd1) ? 2'd0 : phase + 2'd1;
        end
        afrr_pkg::ST_SQRT: if (du_done) begin
          if (phase == 2'd0) rx <= du_res[31:0];
          else if (phase == 2'd1) ry <= du_res[31:0];
          else rms_total <= du_res[31:0];
          phase <= phase + 2'd1;
        end
        afrr_pkg::ST_OUT: begin
          out_valid   <= 1'b1;
          predicted_x <= px;
          rms_x       <= rx;
          rms_y       <= ry;
          final_res   <= 1'b1;
          sum_x <= '0; sum_y <= '0; count <= '0;
        end
        default: ;
      endcase
    end
  end

  // products registered before rounding
  always_ff @(posedge clk) begin
    p1          <= 64'(mul_g1) * 64'(mul_v1);
    p2          <= 64'(mul_g2) * 64'(mul_v2);
    mul_off_reg <= mul_off;
  end

endmodule

### rtl/core/afrr_cfg.sv
// afrr_cfg: coefficient register file written through the configuration channel.
// Depends on afrr_pkg.
module afrr_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic signed [31:0] coef_a,
  output logic signed [31:0] coef_b,
  output logic signed [31:0] coef_c,
  output logic signed [31:0] coef_d,
  output logic signed [31:0] coef_e,
  output logic signed [31:0] coef_f
);

  assign cfg_ready = 1'b1;

  // write the selected coefficient, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= '0;
      coef_b <= afrr_pkg::OneQ824;
      coef_c <= '0;
      coef_d <= '0;
      coef_e <= '0;
      coef_f <= afrr_pkg::OneQ824;
    end else if (cfg_valid) begin
      case (afrr_pkg::reg_idx_t'(cfg_index))
        afrr_pkg::REG_A: coef_a <= cfg_data;
        afrr_pkg::REG_B: coef_b <= cfg_data;
        afrr_pkg::REG_C: coef_c <= cfg_data;
        afrr_pkg::REG_D: coef_d <= cfg_data;
        afrr_pkg::REG_E: coef_e <= cfg_data;
        afrr_pkg::REG_F: coef_f <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/affine_fit_residual_rms.sv
// affine_fit_residual_rms: top level; coefficient registers, input queue and back part.
// Depends on afrr_pkg, afrr_cfg, afrr_front, afrr_back, afrr_divsqrt.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | measured_x/y, expected_x/y, last_sample
//  out     | out_valid / out_stall| predicted_x/y, rms_x/y, rms_total, final_res
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A plain sample passes the back part in two multiplier passes and one accumulate.
// A last sample adds two 64-step divisions and three 32-step roots, all through the one
// shared divide/root unit, then one state to load the output.
// Reset is synchronous; sums, count and coefficients return to their reset values.
// A two-entry queue lets the input side keep filling while the output is stalled.
module affine_fit_residual_rms #(
  parameter int MaxSamples = afrr_pkg::MaxSamplesDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] measured_x,
  input  logic signed [31:0] measured_y,
  input  logic signed [31:0] expected_x,
  input  logic signed [31:0] expected_y,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] predicted_x,
  output logic signed [31:0] predicted_y,
  output logic [31:0]        rms_x,
  output logic [31:0]        rms_y,
  output logic [31:0]        rms_total,
  output logic               final_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic signed [31:0] ca, cb, cc, cd, ce, cf;
  afrr_pkg::sample_t  in_item, q_item;
  logic               q_valid, q_take;

  assign in_item = '{mx: measured_x, my: measured_y, ex: expected_x,
                     ey: expected_y, last: last_sample};

  afrr_cfg u_cfg (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .coef_a(ca), .coef_b(cb), .coef_c(cc), .coef_d(cd), .coef_e(ce), .coef_f(cf)
  );

  afrr_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
  );

  afrr_back #(.MaxSamples(MaxSamples)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .coef_a(ca), .coef_b(cb), .coef_c(cc), .coef_d(cd), .coef_e(ce), .coef_f(cf),
    .out_valid(out_valid), .out_stall(out_stall),
    .predicted_x(predicted_x), .predicted_y(predicted_y),
    .rms_x(rms_x), .rms_y(rms_y), .rms_total(rms_total), .final_res(final_res)
  );

`ifndef NO_ASSERTIONS
  // a stalled result keeps its RMS flag
  a_final_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> final_res == $past(final_res))
    else $error("final flag changed under stall");
  // non-final results carry zero RMS
  a_zero_rms: assert property (@(posedge clk) disable iff (rst)
    out_valid && !final_res |-> rms_x == 32'd0 && rms_total == 32'd0)
    else $error("RMS on non-final result");
`endif

endmodule

### sim/testbench.sv
// testbench: self-checking bench for affine_fit_residual_rms.
// Depends on afrr_pkg and the affine_fit_residual_rms RTL; predicts each result
// with its own affine, accumulate, divide and root arithmetic.
module testbench;

  localparam int CountCap = 65536;
  localparam int IdleLimit = 20000;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0]        rx;
    logic [31:0]        ry;
    logic [31:0]        rt;
    logic               fin;
  } fit_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] measured_x = '0;
  logic signed [31:0] measured_y = '0;
  logic signed [31:0] expected_x = '0;
  logic signed [31:0] expected_y = '0;
  logic last_sample = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] predicted_x;
  logic signed [31:0] predicted_y;
  logic [31:0] rms_x;
  logic [31:0] rms_y;
  logic [31:0] rms_total;
  logic final_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor state
  logic signed [31:0] model_coef [6];
  logic [63:0] acc_sq_x;
  logic [63:0] acc_sq_y;
  int unsigned n_samples;
  fit_result_t expected_results [$];

  int errors = 0;
  int idle_cycles = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit hold_off = 1'b0;

  affine_fit_residual_rms dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // integer square root, floor
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // offset plus two gain products, rounded Q24.40 -> Q16.16, saturated
  function automatic logic signed [31:0] apply_affine(
      input logic signed [31:0] off, input logic signed [31:0] g1,
      input logic signed [31:0] v1, input logic signed [31:0] g2,
      input logic signed [31:0] v2);
    logic signed [127:0] sum;
    sum = (128'(g1) * 128'(v1) + 128'(g2) * 128'(v2) + 128'sd8388608) >>> 24;
    sum = sum + 128'(off);
    if (sum > 128'sd2147483647) return 32'sh7fff_ffff;
    if (sum < -128'sd2147483648) return 32'sh8000_0000;
    return sum[31:0];
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] s, input logic [63:0] v);
    logic [64:0] r;
    r = {1'b0, s} + {1'b0, v};
    return r[64] ? '1 : r[63:0];
  endfunction

  // work out the result of one sample and update the sums
  function automatic fit_result_t predict_fit(input logic signed [31:0] xm,
      input logic signed [31:0] ym, input logic signed [31:0] xe,
      input logic signed [31:0] ye, input logic last);
    fit_result_t r;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0] adx;
    logic [32:0] ady;
    logic [63:0] mx;
    logic [63:0] my;
    logic [64:0] mt;
    r.px = apply_affine(model_coef[afrr_pkg::REG_A], model_coef[afrr_pkg::REG_B], xm,
                        model_coef[afrr_pkg::REG_C], ym);
    r.py = apply_affine(model_coef[afrr_pkg::REG_D], model_coef[afrr_pkg::REG_E], xm,
                        model_coef[afrr_pkg::REG_F], ym);
    dx = 33'(xe) - 33'(r.px);
    dy = 33'(ye) - 33'(r.py);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    acc_sq_x = add_sat(acc_sq_x, 64'(adx) * 64'(adx));
    acc_sq_y = add_sat(acc_sq_y, 64'(ady) * 64'(ady));
    if (n_samples < CountCap) n_samples++;
    r.rx = '0;
    r.ry = '0;
    r.rt = '0;
    r.fin = 1'b0;
    if (last) begin
      mx = acc_sq_x / 64'(n_samples);
      my = acc_sq_y / 64'(n_samples);
      mt = {1'b0, mx} + {1'b0, my};
      r.rx = 32'(isqrt(mx));
      r.ry = 32'(isqrt(my));
      r.rt = mt[64] ? '1 : 32'(isqrt(mt[63:0]));
      r.fin = 1'b1;
      acc_sq_x = '0;
      acc_sq_y = '0;
      n_samples = 0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // offer one item, with an optional gap first; valid stays up after acceptance
  task automatic send_sample(input logic signed [31:0] xm, input logic signed [31:0] ym,
      input logic signed [31:0] xe, input logic signed [31:0] ye, input logic last);
    if (send_gaps && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (send_gaps && $urandom_range(99) < 36) @(posedge clk);
    end
    in_valid <= 1'b1;
    measured_x <= xm;
    measured_y <= ym;
    expected_x <= xe;
    expected_y <= ye;
    last_sample <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_fit(xm, ym, xe, ye, last));
  endtask

  task automatic write_coef(input logic [2:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx <= afrr_pkg::REG_F) model_coef[idx] = value;
    @(posedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // drain all results, then let the block settle
  task automatic wait_idle();
    drain();
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(3) == 0 ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(2000000))) - 32'sd1000000;
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(3))
      0: return $urandom;
      default: return 32'h0100_0000 + 32'($signed($urandom_range(400000))) - 32'sd200000;
    endcase
  endfunction

  task automatic test_directed();
    send_sample(0, 0, 0, 0, 1'b1);
    send_sample(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
    send_sample(32'sh0001_0000, -32'sh0001_0000, 32'sh0001_8000, 0, 1'b1);
    // saturating sums: large residuals many times over
    for (int i = 0; i < 8; i++)
      send_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, i == 7);
    wait_idle();
    // extreme gains drive the predictions into saturation
    write_coef(afrr_pkg::REG_A, 32'h7fff_ffff);
    write_coef(afrr_pkg::REG_B, 32'h7fff_ffff);
    write_coef(afrr_pkg::REG_C, 32'h8000_0000);
    write_coef(afrr_pkg::REG_D, 32'h8000_0000);
    write_coef(afrr_pkg::REG_E, 32'h8000_0000);
    write_coef(afrr_pkg::REG_F, 32'h7fff_ffff);
    write_coef(3'd7, 32'h1234_5678);
    send_sample(32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 1'b0);
    send_sample(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 1'b0);
    send_sample(32'sh0000_0001, -32'sh0000_0001, 0, 32'sh8000_0000, 1'b1);
    wait_idle();
    write_coef(afrr_pkg::REG_A, 0);
    write_coef(afrr_pkg::REG_B, 0);
    write_coef(afrr_pkg::REG_C, 0);
    write_coef(afrr_pkg::REG_D, 0);
    write_coef(afrr_pkg::REG_E, 0);
    write_coef(afrr_pkg::REG_F, 0);
    send_sample(32'sh1234_5678, 32'sh8765_4321, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
    wait_idle();
  endtask

  task automatic test_random(input int total);
    int sent;
    bit pressed;
    sent = 0;
    pressed = 1'b0;
    while (sent < total) begin
      for (int k = 0; k < 6; k++) write_coef(k[2:0], $urandom_range(5) == 0 ?
          ($urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000) :
          (k == afrr_pkg::REG_A || k == afrr_pkg::REG_D ? rand_coord() : rand_gain()));
      // one set, usually short; quiet stretch in the middle phase
      if (sent > total / 3 && sent < total / 2) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end else begin
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
      end
      begin
        int len;
        len = $urandom_range(3) == 0 ? $urandom_range(40, 1) : $urandom_range(6, 1);
        for (int j = 0; j < len; j++) begin
          send_sample(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      j == len - 1);
          sent++;
        end
      end
      if ($urandom_range(3) == 0) wait_idle();
      else drain();
      if (!pressed && sent > total / 5) begin
        // long hold-off while the sender keeps offering
        pressed = 1'b1;
        hold_off = 1'b1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
        for (int j = 0; j < 8; j++) begin
          send_sample(rand_coord(), rand_coord(), rand_coord(), rand_coord(), j == 7);
          sent++;
        end
        wait_idle();
      end
      wait_idle();
    end
  endtask

  // receiver stall
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || (recv_gaps && $urandom_range(99) < 36);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", predicted_x, 0);
      end else begin
        fit_result_t e;
        e = expected_results.pop_front();
        if (predicted_x !== e.px) report_mismatch("predicted_x", predicted_x, e.px);
        if (predicted_y !== e.py) report_mismatch("predicted_y", predicted_y, e.py);
        if (rms_x !== e.rx) report_mismatch("rms_x", rms_x, e.rx);
        if (rms_y !== e.ry) report_mismatch("rms_y", rms_y, e.ry);
        if (rms_total !== e.rt) report_mismatch("rms_total", rms_total, e.rt);
        if (final_res !== e.fin)
          report_mismatch("final_res", 32'(final_res), 32'(e.fin));
      end
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    model_coef[afrr_pkg::REG_A] = 0;
    model_coef[afrr_pkg::REG_B] = afrr_pkg::OneQ824;
    model_coef[afrr_pkg::REG_C] = 0;
    model_coef[afrr_pkg::REG_D] = 0;
    model_coef[afrr_pkg::REG_E] = 0;
    model_coef[afrr_pkg::REG_F] = afrr_pkg::OneQ824;
    acc_sq_x = '0;
    acc_sq_y = '0;
    n_samples = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1250);
    wait_idle();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

### sim.f
rtl/core/afrr_pkg.sv
rtl/core/afrr_front.sv
rtl/core/afrr_divsqrt.sv
rtl/core/afrr_back.sv
rtl/core/afrr_cfg.sv
rtl/core/affine_fit_residual_rms.sv
sim/testbench.sv
